// File: rtl/core/fss_pkg.sv
// Shared types, constants and helper functions for the fuzzy subsequence scorer.
`default_nettype none

package fss_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned WORD_BYTES   = CFG_DATA_W / BYTE_W;
  localparam int unsigned SUM_W        = 14;
  localparam int unsigned SCORE_W      = 15;
  localparam int unsigned OUT_TDATA_W  = 16;

  localparam int unsigned DEF_MAX_QUERY = 32;
  localparam int unsigned DEF_MAX_TEXT  = 4095;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD_0 = 3'd1;

  // Score terms
  localparam int unsigned SUM_MAX      = 16383;
  localparam int unsigned BASE_ADD     = 10;
  localparam int unsigned RUN_SHIFT    = 3;
  localparam int unsigned START_BONUS  = 20;
  localparam int unsigned SEP_BONUS    = 15;
  localparam int unsigned PREFIX_BONUS = 40;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      matched;
  } fss_result_t;

  // ASCII-only lower-case fold
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Whitespace or word separator that earns the boundary bonus
  function automatic logic is_separator(input logic [BYTE_W-1:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h2D ||
           c == 8'h5F || c == 8'h2E || c == 8'h2F;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fss_cfg_regs.sv
// Configuration register file holding the query length and query bytes.
`default_nettype none

module fss_cfg_regs #(
  parameter int unsigned MAX_QUERY = fss_pkg::DEF_MAX_QUERY
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  wire logic [fss_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  output logic [fss_pkg::LEN_W-1:0]                       needle_len_o,
  output logic [MAX_QUERY-1:0][fss_pkg::BYTE_W-1:0]       needle_o
);
  import fss_pkg::*;

  logic                                 wr_en;
  logic [LEN_W-1:0]                     len_q;
  logic [MAX_QUERY-1:0][BYTE_W-1:0]     needle_q;

  assign cfg_ready_o  = 1'b1;
  assign wr_en        = cfg_valid_i & cfg_ready_o;
  assign needle_len_o = len_q;
  assign needle_o     = needle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (wr_en && cfg_index_i == REG_NEEDLE_LENGTH) begin
      len_q <= cfg_data_i[LEN_W-1:0];
    end
  end

  // Each query byte sits in a fixed lane of one configuration word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
    end else if (wr_en) begin
      for (int b = 0; b < MAX_QUERY; b++) begin
        if (cfg_index_i == CFG_IDX_W'(int'(REG_NEEDLE_WORD_0) + b / WORD_BYTES)) begin
          needle_q[b] <= cfg_data_i[(b % WORD_BYTES)*BYTE_W +: BYTE_W];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fss_match_unit.sv
// Candidate state registers and the per-byte match and score update.
`default_nettype none

module fss_match_unit #(
  parameter int unsigned MAX_QUERY = fss_pkg::DEF_MAX_QUERY,
  parameter int unsigned MAX_TEXT  = fss_pkg::DEF_MAX_TEXT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [fss_pkg::BYTE_W-1:0]           byte_i,
  input  wire logic                                 last_i,
  input  wire logic [fss_pkg::LEN_W-1:0]            needle_len_i,
  input  wire logic [MAX_QUERY-1:0][fss_pkg::BYTE_W-1:0] needle_i,
  output fss_pkg::fss_result_t                      result_o
);
  import fss_pkg::*;

  localparam int unsigned POS_W   = $clog2(MAX_QUERY + 1);
  localparam int unsigned QIDX_W  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int unsigned TXT_W   = $clog2(MAX_TEXT + 1);
  localparam int unsigned THIRD_W = $clog2(MAX_TEXT / 3 + 1);
  localparam int unsigned RES_W   = ((THIRD_W > SUM_W + 1) ? THIRD_W : SUM_W + 1) + 2;
  localparam logic signed [RES_W-1:0] ResHi = RES_W'((2 ** (SCORE_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] ResLo = -ResHi - RES_W'(1);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [POS_W-1:0]   run_q, run_d;
  logic [BYTE_W-1:0]  prev_q;
  logic [TXT_W-1:0]   txt_q, txt_d;
  logic [THIRD_W-1:0] third_q, third_d;
  logic [1:0]         mod_q, mod_d;
  logic               prefix_q, prefix_d;

  logic [BYTE_W-1:0]      c;
  logic [POS_W-1:0]       len_eff;
  logic                   active, hit;
  logic [SCORE_W-1:0]     add, sum_ext;
  logic signed [RES_W-1:0] res_full;

  always_comb begin
    c       = fold_byte(byte_i);
    len_eff = (needle_len_i > LEN_W'(MAX_QUERY)) ? POS_W'(MAX_QUERY) : POS_W'(needle_len_i);
    active  = pos_q < len_eff;
    hit     = active && (c == fold_byte(needle_i[pos_q[QIDX_W-1:0]]));

    add = SCORE_W'(BASE_ADD) + (SCORE_W'(run_q) << RUN_SHIFT);
    if (txt_q == '0) begin
      add = add + SCORE_W'(START_BONUS);
    end else if (is_separator(prev_q)) begin
      add = add + SCORE_W'(SEP_BONUS);
    end
    sum_ext = SCORE_W'(sum_q) + add;

    pos_d    = pos_q;
    sum_d    = sum_q;
    run_d    = run_q;
    prefix_d = prefix_q;
    if (hit) begin
      sum_d = (sum_ext > SCORE_W'(SUM_MAX)) ? SUM_W'(SUM_MAX) : sum_ext[SUM_W-1:0];
      run_d = run_q + POS_W'(1);
      pos_d = pos_q + POS_W'(1);
    end else if (active) begin
      run_d    = '0;
      prefix_d = 1'b0;
    end

    // Saturating length with a running divide-by-three alongside
    txt_d   = txt_q;
    third_d = third_q;
    mod_d   = mod_q;
    if (txt_q < TXT_W'(MAX_TEXT)) begin
      txt_d = txt_q + TXT_W'(1);
      if (mod_q == 2'd2) begin
        mod_d   = 2'd0;
        third_d = third_q + THIRD_W'(1);
      end else begin
        mod_d = mod_q + 2'd1;
      end
    end

    res_full = $signed(RES_W'(sum_d)) - $signed(RES_W'(third_d));
    if (prefix_d) begin
      res_full = res_full + RES_W'(PREFIX_BONUS);
    end

    if (len_eff == '0) begin
      result_o.score   = '0;
      result_o.matched = 1'b1;
    end else if (pos_d >= len_eff) begin
      if (res_full > ResHi) begin
        result_o.score = SCORE_W'(ResHi);
      end else if (res_full < ResLo) begin
        result_o.score = SCORE_W'(ResLo);
      end else begin
        result_o.score = res_full[SCORE_W-1:0];
      end
      result_o.matched = 1'b1;
    end else begin
      result_o.score   = '1;
      result_o.matched = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      run_q    <= '0;
      prev_q   <= '0;
      txt_q    <= '0;
      third_q  <= '0;
      mod_q    <= '0;
      prefix_q <= 1'b1;
    end else if (step_i) begin
      if (last_i) begin
        pos_q    <= '0;
        sum_q    <= '0;
        run_q    <= '0;
        prev_q   <= '0;
        txt_q    <= '0;
        third_q  <= '0;
        mod_q    <= '0;
        prefix_q <= 1'b1;
      end else begin
        pos_q    <= pos_d;
        sum_q    <= sum_d;
        run_q    <= run_d;
        prev_q   <= c;
        txt_q    <= txt_d;
        third_q  <= third_d;
        mod_q    <= mod_d;
        prefix_q <= prefix_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fuzzy_subsequence_scorer_core.sv
// Top level of the fuzzy subsequence scorer: configuration registers, input stage, match unit, result register.
// A taken word is held in the input stage; the score for a last byte is then registered in the result register.
// Throughput: one haystack byte per cycle while a last byte is not held back by a full result register,
//   set by the state update loop in the match unit; the output register lets the next byte enter while a score waits.
// Reset (rst_ni low, asynchronous): empty query, cleared candidate state, no result held.
`default_nettype none

module fuzzy_subsequence_scorer_core #(
  parameter int unsigned MAX_QUERY = fss_pkg::DEF_MAX_QUERY,
  parameter int unsigned MAX_TEXT  = fss_pkg::DEF_MAX_TEXT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Haystack stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [fss_pkg::BYTE_W-1:0]         s_axis_tdata_i,  // [7:0] haystack_byte
  input  wire logic                               s_axis_tlast_i,  // last_byte
  // Score stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [fss_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,  // [14:0] match_score, [15] zero
  output logic                                    m_axis_tuser_o   // matched
);
  import fss_pkg::*;

  logic [LEN_W-1:0]                 needle_len;
  logic [MAX_QUERY-1:0][BYTE_W-1:0] needle;

  // Input stage
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              in_take, in_adv, out_free;

  // Result register
  logic        out_valid_q, out_valid_d;
  fss_result_t out_res_q, step_res;

  fss_cfg_regs #(
    .MAX_QUERY(MAX_QUERY)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .needle_len_o(needle_len),
    .needle_o    (needle)
  );

  // A byte that ends the candidate advances only when the result register has room;
  // every other byte advances at once since it produces nothing.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_adv          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || in_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  fss_match_unit #(
    .MAX_QUERY(MAX_QUERY),
    .MAX_TEXT (MAX_TEXT)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_adv),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .needle_len_i(needle_len),
    .needle_i    (needle),
    .result_o    (step_res)
  );

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (in_adv ? 1'b0 : in_valid_q);
    if (in_adv && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the word until the stage moves on
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (in_adv && in_last_q) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - SCORE_W){1'b0}}, out_res_q.score};
  assign m_axis_tuser_o  = out_res_q.matched;

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fuzzy subsequence scorer core.
module testbench;
  import fss_pkg::*;

  // Limits and score terms of the scorer, kept apart from the RTL copies
  localparam int unsigned QUERY_CAP    = 32;
  localparam int unsigned TEXT_CAP     = 4095;
  localparam int unsigned SUM_CAP      = 16383;
  localparam int          SCORE_HIGH   = 16383;
  localparam int          SCORE_LOW    = -16384;
  localparam int unsigned MATCH_BASE   = 10;
  localparam int unsigned RUN_STEP     = 8;
  localparam int unsigned LEAD_BONUS   = 20;
  localparam int unsigned BREAK_BONUS  = 15;
  localparam int unsigned PREFIX_EXTRA = 40;
  localparam int          NO_MATCH     = -1;

  // Index that maps to no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 160;
  localparam int SETTLE_TICKS = 4;
  localparam int MAX_PRINTS   = 40;
  localparam int PHASE_BYTES  = 60;

  localparam logic [7:0] SEPARATORS [11] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20,
                                             8'h2D, 8'h5F, 8'h2E, 8'h2F, 8'h20};

  // Tracks the query and the candidate in progress, and holds the scores still owed
  class fuzzy_score_predictor;
    logic [LEN_W-1:0]      needle_len;
    logic [CFG_DATA_W-1:0] needle_words [4];
    int unsigned           found;
    int unsigned           run;
    int unsigned           seen;
    int unsigned           sum;
    logic [BYTE_W-1:0]     prev;
    bit                    prefix_ok;
    fss_result_t           owed_scores [$];
    int unsigned           failures;
    int unsigned           scores_checked;
    int unsigned           bytes_taken;
    int unsigned           reg_writes;

    function new();
      needle_len = '0;
      foreach (needle_words[w]) needle_words[w] = '0;
      failures = 0;
      scores_checked = 0;
      bytes_taken = 0;
      reg_writes = 0;
      clear_candidate();
    endfunction

    function void clear_candidate();
      found = 0;
      run = 0;
      seen = 0;
      sum = 0;
      prev = '0;
      prefix_ok = 1'b1;
    endfunction

    function logic [BYTE_W-1:0] fold_case(logic [BYTE_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function bit breaks_word(logic [BYTE_W-1:0] c);
      return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h2D ||
             c == 8'h5F || c == 8'h2E || c == 8'h2F;
    endfunction

    function logic [BYTE_W-1:0] needle_byte(int unsigned k);
      return needle_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function int unsigned active_len();
      return (needle_len > QUERY_CAP) ? QUERY_CAP : needle_len;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      if (idx == REG_NEEDLE_LENGTH)
        needle_len = val[LEN_W-1:0];
      else if (idx >= REG_NEEDLE_WORD_0 && idx < REG_NEEDLE_WORD_0 + 3'd4)
        needle_words[idx - REG_NEEDLE_WORD_0] = val;
    endfunction

    // Advance the candidate by one text byte; owe a score on the last one
    function void note_byte(logic [BYTE_W-1:0] raw, logic last);
      logic [BYTE_W-1:0] c;
      int unsigned       lim;
      int unsigned       gain;
      int                total;
      fss_result_t       r;
      bytes_taken++;
      c = fold_case(raw);
      lim = active_len();
      if (found < lim) begin
        if (c == fold_case(needle_byte(found))) begin
          gain = MATCH_BASE + RUN_STEP * run;
          if (seen == 0)
            gain += LEAD_BONUS;
          else if (breaks_word(prev))
            gain += BREAK_BONUS;
          sum += gain;
          if (sum > SUM_CAP) sum = SUM_CAP;
          run = (run + 1) & 6'h3F;
          found++;
        end else begin
          run = 0;
          prefix_ok = 1'b0;
        end
      end
      prev = c;
      if (seen < TEXT_CAP) seen++;
      if (!last) return;
      if (lim == 0) begin
        total = 0;
        r.matched = 1'b1;
      end else if (found >= lim) begin
        total = int'(sum) + (prefix_ok ? PREFIX_EXTRA : 0) - int'(seen / 3);
        if (total > SCORE_HIGH) total = SCORE_HIGH;
        if (total < SCORE_LOW) total = SCORE_LOW;
        r.matched = 1'b1;
      end else begin
        total = NO_MATCH;
        r.matched = 1'b0;
      end
      r.score = total[SCORE_W-1:0];
      owed_scores = {owed_scores, r};
      clear_candidate();
    endfunction

    task report_mismatch(string msg);
      failures++;
      if (failures <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_score(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      fss_result_t want;
      if (owed_scores.size() == 0) begin
        report_mismatch($sformatf("score word 0x%h with none owed", tdata));
        return;
      end
      want = owed_scores.pop_front();
      scores_checked++;
      if (tdata[SCORE_W-1:0] !== want.score)
        report_mismatch($sformatf("score #%0d: got %0d, want %0d", scores_checked,
                                  $signed(tdata[SCORE_W-1:0]), $signed(want.score)));
      if (tuser !== want.matched)
        report_mismatch($sformatf("score #%0d: matched %b, want %b", scores_checked,
                                  tuser, want.matched));
      if (tdata[OUT_TDATA_W-1] !== 1'b0)
        report_mismatch($sformatf("score #%0d: pad bit set", scores_checked));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [BYTE_W-1:0]      s_axis_tdata_i;   // [7:0] haystack_byte
  logic                   s_axis_tlast_i;   // last_byte
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [14:0] match_score, [15] zero
  logic                   m_axis_tuser_o;   // matched

  fuzzy_score_predictor sb;
  logic [BYTE_W-1:0]     cand [$];
  logic [CFG_DATA_W-1:0] fresh_words [4];
  bit                    calm;
  bit                    hold_req;
  int                    stall_left;
  int                    quiet_cycles;

  fuzzy_subsequence_scorer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Score receiver: check every accepted word, then pick next cycle's tready.
  // A hold-off request parks tready low for a long stretch so the core backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_score(m_axis_tdata_o, m_axis_tuser_o);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req <= 1'b0;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles, %0d scores still owed",
                   QUIET_LIMIT, sb.owed_scores.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Offer one text byte, idling first at random; tvalid stays high afterwards
  task automatic offer_byte(logic [BYTE_W-1:0] b, logic last);
    if (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, last);
  endtask

  task automatic send_chars(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      offer_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic send_text();
    for (int i = 0; i < cand.size(); i++)
      offer_byte(cand[i], i == cand.size() - 1);
  endtask

  // Drop tvalid, wait out every owed score, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Hold cfg_valid high across a batch; the caller lowers it afterwards
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, val);
  endtask

  task automatic write_needle(int unsigned len, bit with_spare);
    write_reg(REG_NEEDLE_LENGTH, CFG_DATA_W'(len));
    for (int w = 0; w < 4; w++)
      write_reg(REG_NEEDLE_WORD_0 + CFG_IDX_W'(w), fresh_words[w]);
    if (with_spare) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] flip_case(logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] filler();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'($urandom_range(8'h7A, 8'h61));
      5:             return 8'($urandom_range(8'h5A, 8'h41));
      6:             return SEPARATORS[$urandom_range(10)];
      7:             return 8'($urandom_range(8'h39, 8'h30));
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly letters so that random text has a fair chance of matching
  function automatic void roll_needle();
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < QUERY_CAP; k++) begin
      case ($urandom_range(9))
        0:       b = 8'($urandom_range(8'h5A, 8'h41));
        1:       b = SEPARATORS[$urandom_range(10)];
        2:       b = 8'($urandom_range(255));
        default: b = 8'($urandom_range(8'h7A, 8'h61));
      endcase
      fresh_words[k / 8][(k % 8) * 8 +: 8] = b;
    end
  endfunction

  // Append one byte to the candidate under construction
  function automatic void add_to_text(logic [BYTE_W-1:0] b);
    cand = {cand, b};
  endfunction

  // Build one candidate: mostly the query planted with random filler and case,
  // some with one query byte dropped, some pure noise
  function automatic void build_candidate();
    int unsigned lim;
    int unsigned mode;
    int unsigned pct;
    int unsigned skip;
    cand.delete();
    lim = sb.active_len();
    mode = $urandom_range(99);
    if (mode < 15 || lim == 0) begin
      repeat ($urandom_range(12, 1)) add_to_text(8'($urandom_range(255)));
      return;
    end
    pct = ($urandom_range(4) == 0) ? 0 : $urandom_range(60, 20);
    skip = (mode < 30) ? $urandom_range(lim - 1) : QUERY_CAP;
    for (int unsigned k = 0; k < lim; k++) begin
      while ($urandom_range(99) < pct) add_to_text(filler());
      if (k != skip) add_to_text(flip_case(sb.needle_byte(k)));
    end
    repeat ($urandom_range(4)) add_to_text(filler());
    if (cand.size() == 0) add_to_text(filler());
  endfunction

  initial begin
    int unsigned len;
    int unsigned sent;
    sb = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty query straight out of reset, with the byte extremes
    offer_byte(8'h78, 1'b1);
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hFF, 1'b1);
    drain();

    // Query "Abc": upper case in the query folds too
    fresh_words = '{64'h0000_0000_0063_6241, '0, '0, '0};
    write_needle(3, 1'b0);
    send_chars("abc", 1'b1);          // leading bonus, run growth, whole prefix
    send_chars("x-a\tb/c", 1'b1);     // word-break bonuses after '-', tab and '/'
    send_chars("ab", 1'b1);           // query incomplete
    send_chars("ABC", 1'b0);
    offer_byte(8'hC1, 1'b1);          // high byte: not folded, not a separator
    send_chars("abcZZ", 1'b1);        // bytes after completion only add length
    send_chars("ab", 1'b0);
    drain();
    // Shorten the query mid-candidate: position already reached counts as complete
    write_reg(REG_NEEDLE_LENGTH, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    send_chars("z", 1'b1);
    drain();

    // Random phases across query lengths, extremes included
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       len = 1;
        1:       len = QUERY_CAP;
        2:       len = 63;              // above the cap, clamps to 32
        3:       len = 0;
        default: len = $urandom_range(QUERY_CAP - 1, 2);
      endcase
      roll_needle();
      write_needle(len, p == 4);
      calm <= (p == 5);
      if (p == 0) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_candidate();
        send_text();
        sent += cand.size();
      end
      drain();
    end
    calm <= 1'b0;

    repeat (8) @(posedge clk_i);
    if (sb.owed_scores.size() != 0)
      sb.report_mismatch($sformatf("%0d scores never arrived", sb.owed_scores.size()));
    $display("Run covered %0d text bytes, %0d scores checked, %0d register writes.",
             sb.bytes_taken, sb.scores_checked, sb.reg_writes);
    $display("Queries from empty to above the cap, a length cut mid-text, one long stall.");
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
